>>> design/bnfra_pkg.sv
// bnfra_pkg: shared types, codes and widths of the bitmap next-fit run allocator
// depends on nothing; every other design file refers to it by scoped names

package bnfra_pkg;

    // field widths fixed by the block's interface
    localparam int FUNC_W  = 2;
    localparam int BLOCK_W = 16;
    localparam int CNT_W   = 17;
    localparam int WORD_W  = 64;

    // default bitmap capacity and register value after reset
    localparam int MAX_BLOCKS_DEF = 65536;
    localparam int RESET_BLOCKS   = 65536;

    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [WORD_W-1:0]  t_word;

    // operation codes of a request word
    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR = 2'd0,
        FN_MARK  = 2'd1,
        FN_ALLOC = 2'd2
    } t_func;

    // kind of response word to build
    typedef enum logic [1:0] {
        RES_ZERO    = 2'd0,
        RES_NOSPACE = 2'd1,
        RES_GRANT   = 2'd2
    } t_res;

    // outcome of one byte-lane scan step
    typedef struct packed {
        logic       done;
        logic [3:0] k;
        logic       start_hit;
        logic [2:0] start_off;
        logic [3:0] end_pos;
    } t_scan_res;

    // controller to datapath
    typedef struct packed {
        logic req_load;
        logic clear_init;
        logic sweep_step;
        logic mark_init;
        logic alloc_mark_init;
        logic mark_rd;
        logic mark_wr;
        logic scan_init;
        logic scan_rd;
        logic scan_chunk;
        logic scan_wrap;
        logic scan_stop;
        logic out_load;
        t_res res_kind;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_func func;
        logic  mark_empty;
        logic  no_space;
        logic  sweep_last;
        logic  mark_last;
        logic  at_lim;
        logic  run_zero;
        logic  wrapped;
        logic  scan_done;
        logic  word_next;
        logic  out_free;
    } t_dp_status;

endpackage

>>> design/bnfra_if.sv
// bnfra_if: channel interfaces for request, response and register write words
// depends on bnfra_pkg for the payload types

interface bnfra_req_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            func;
    bnfra_pkg::t_block     first_block;
    bnfra_pkg::t_cnt       run_length;

    modport source (output valid, output func, output first_block, output run_length,
                    input ready);
    modport sink   (input valid, input func, input first_block, input run_length,
                    output ready);
endinterface

interface bnfra_rsp_if;
    logic                  valid;
    logic                  ready;
    bnfra_pkg::t_block     granted_start;
    bnfra_pkg::t_cnt       granted_count;
    logic                  status;

    modport source (output valid, output granted_start, output granted_count,
                    output status, input ready);
    modport sink   (input valid, input granted_start, input granted_count,
                    input status, output ready);
endinterface

interface bnfra_cfg_if;
    logic                  valid;
    logic                  ready;
    bnfra_pkg::t_cnt       blocks_in_use;

    modport source (output valid, output blocks_in_use, input ready);
    modport sink   (input valid, input blocks_in_use, output ready);
endinterface

>>> design/bnfra_scan.sv
// bnfra_scan: examines one byte lane of the used map for the next-fit scan
// depends on bnfra_pkg for the step result type

module bnfra_scan (
    input  logic [7:0]           i_bits,
    input  logic [2:0]           i_off,
    input  logic [3:0]           i_vend,
    input  logic                 i_run_zero,
    input  logic [3:0]           i_need_cap,
    output bnfra_pkg::t_scan_res o_res
);

    // walk the lane from the cursor offset up to the scan limit
    always_comb begin
        o_res = '0;
        o_res.end_pos = i_vend;
        for (int p = 0; p < 8; p++) begin
            if (!o_res.done && (4'(p) >= {1'b0, i_off}) && (4'(p) < i_vend)) begin
                if (!i_bits[p]) begin
                    // free block: open or extend the run
                    if (i_run_zero && (o_res.k == 4'd0)) begin
                        o_res.start_hit = 1'b1;
                        o_res.start_off = 3'(p);
                    end
                    o_res.k = o_res.k + 4'd1;
                    if (o_res.k == i_need_cap) begin
                        o_res.done    = 1'b1;
                        o_res.end_pos = 4'(p + 1);
                    end
                end else if (!i_run_zero || (o_res.k != 4'd0)) begin
                    // used block ends an open run
                    o_res.done    = 1'b1;
                    o_res.end_pos = 4'(p + 1);
                end
            end
        end
    end

endmodule

>>> design/bnfra_ctrl.sv
// bnfra_ctrl: sequencer for clear sweeps, range marking and next-fit scans
// depends on bnfra_pkg for the command and status structs

module bnfra_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  bnfra_pkg::t_dp_status i_status,
    output bnfra_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [8:0] {
        S_SWEEP   = 9'b000000001,
        S_IDLE    = 9'b000000010,
        S_DECODE  = 9'b000000100,
        S_MARK_RD = 9'b000001000,
        S_MARK_WR = 9'b000010000,
        S_SCAN_RD = 9'b000100000,
        S_SCAN    = 9'b001000000,
        S_GRANT   = 9'b010000000,
        S_FINISH  = 9'b100000000
    } t_state;

    t_state          r_state, n_state;
    bnfra_pkg::t_res r_kind, n_kind;
    logic            r_reply, n_reply;

    assign o_req_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_reply = r_reply;
        o_cmd   = '0;
        o_cmd.res_kind = r_kind;
        unique case (r_state)
            S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_status.sweep_last) begin
                    n_reply = 1'b0;
                    n_state = r_reply ? S_FINISH : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.req_load = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_kind = bnfra_pkg::RES_ZERO;
                unique case (i_status.func)
                    bnfra_pkg::FN_CLEAR: begin
                        o_cmd.clear_init = 1'b1;
                        n_reply = 1'b1;
                        n_state = S_SWEEP;
                    end
                    bnfra_pkg::FN_MARK: begin
                        if (i_status.mark_empty) begin
                            n_state = S_FINISH;
                        end else begin
                            o_cmd.mark_init = 1'b1;
                            n_state = S_MARK_RD;
                        end
                    end
                    bnfra_pkg::FN_ALLOC: begin
                        if (i_status.no_space) begin
                            n_kind  = bnfra_pkg::RES_NOSPACE;
                            n_state = S_FINISH;
                        end else begin
                            o_cmd.scan_init = 1'b1;
                            n_state = S_SCAN_RD;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_MARK_RD: begin
                o_cmd.mark_rd = 1'b1;
                n_state = S_MARK_WR;
            end
            S_MARK_WR: begin
                o_cmd.mark_wr = 1'b1;
                n_state = i_status.mark_last ? S_FINISH : S_MARK_RD;
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_status.at_lim) begin
                    // limit reached: grant, give up, or wrap to block zero
                    if (i_status.wrapped || !i_status.run_zero) begin
                        o_cmd.scan_stop = 1'b1;
                        if (!i_status.run_zero) begin
                            n_kind  = bnfra_pkg::RES_GRANT;
                            n_state = S_GRANT;
                        end else begin
                            n_kind  = bnfra_pkg::RES_NOSPACE;
                            n_state = S_FINISH;
                        end
                    end else begin
                        o_cmd.scan_wrap = 1'b1;
                        n_state = S_SCAN_RD;
                    end
                end else begin
                    o_cmd.scan_chunk = 1'b1;
                    if (i_status.scan_done) begin
                        n_kind  = bnfra_pkg::RES_GRANT;
                        n_state = S_GRANT;
                    end else if (i_status.word_next) begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_GRANT: begin
                o_cmd.alloc_mark_init = 1'b1;
                n_state = S_MARK_RD;
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_kind  <= bnfra_pkg::RES_ZERO;
            r_reply <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_reply <= n_reply;
        end
    end

endmodule

>>> design/bnfra_dp.sv
// bnfra_dp: used-block map memory, cursor, free count, scan and mark datapath
// depends on bnfra_pkg and on bnfra_scan for the byte-lane step

module bnfra_dp #(
    parameter int MAX_BLOCKS = bnfra_pkg::MAX_BLOCKS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bnfra_pkg::t_dp_cmd    i_cmd,
    output bnfra_pkg::t_dp_status o_status,
    input  logic [1:0]            i_req_func,
    input  bnfra_pkg::t_block     i_req_first,
    input  bnfra_pkg::t_cnt       i_req_len,
    input  logic                  i_cfg_valid,
    input  bnfra_pkg::t_cnt       i_cfg_data,
    input  logic                  i_rsp_ready,
    output logic                  o_rsp_valid,
    output bnfra_pkg::t_block     o_rsp_start,
    output bnfra_pkg::t_cnt       o_rsp_count,
    output logic                  o_rsp_status
);

    localparam int MAP_WORDS   = (MAX_BLOCKS + 63) / 64;
    localparam int AW          = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int RESET_TOTAL = (MAX_BLOCKS < bnfra_pkg::RESET_BLOCKS) ?
                                 MAX_BLOCKS : bnfra_pkg::RESET_BLOCKS;

    // map memory and its read register
    bnfra_pkg::t_word r_map [MAP_WORDS];
    bnfra_pkg::t_word r_rdata;

    // control state
    bnfra_pkg::t_cnt  r_total, r_cursor, r_free;
    logic [AW-1:0]    r_sweep;
    logic             r_out_valid;

    // payload state
    bnfra_pkg::t_func  r_func;
    bnfra_pkg::t_block r_first;
    bnfra_pkg::t_cnt   r_len;
    bnfra_pkg::t_cnt   r_mblk, r_hi;
    bnfra_pkg::t_cnt   r_cur, r_lim, r_saved, r_run, r_need, r_start;
    logic              r_wrapped;
    bnfra_pkg::t_block r_out_start;
    bnfra_pkg::t_cnt   r_out_count;
    logic              r_out_status;

    logic [17:0]          w_sum;
    bnfra_pkg::t_cnt      w_mark_hi, w_want, w_hi_last, w_pop, w_free_dec;
    bnfra_pkg::t_cnt      w_new_cur, w_wrap_lim;
    logic                 w_mark_empty, w_last, w_sin_range, w_word_next;
    bnfra_pkg::t_word     w_lo_mask, w_hi_mask, w_mask;
    logic [31:0]          w_mword32, w_sword32;
    logic [AW-1:0]        w_maddr, w_saddr, w_waddr, w_raddr;
    logic                 w_we, w_re;
    bnfra_pkg::t_word     w_wdata;
    logic [7:0]           w_bits;
    logic [3:0]           w_vend, w_need_cap;
    bnfra_pkg::t_scan_res w_scan;

    // mark range decode from the request word
    assign w_sum        = {2'b00, r_first} + {1'b0, r_len};
    assign w_mark_hi    = (w_sum > {1'b0, r_total}) ? r_total : w_sum[16:0];
    assign w_mark_empty = (r_len == '0) || ({1'b0, r_first} >= r_total);
    assign w_want       = (r_len == '0) ? bnfra_pkg::t_cnt'(1) : r_len;

    // per-word mark mask and newly set count
    assign w_hi_last  = r_hi - bnfra_pkg::t_cnt'(1);
    assign w_last     = (w_hi_last[16:6] == r_mblk[16:6]);
    assign w_lo_mask  = {64{1'b1}} << r_mblk[5:0];
    assign w_hi_mask  = w_last ? ({64{1'b1}} >> (6'd63 - w_hi_last[5:0])) : {64{1'b1}};
    assign w_mask     = w_lo_mask & w_hi_mask;
    assign w_pop      = bnfra_pkg::t_cnt'($countones(w_mask & ~r_rdata));
    assign w_free_dec = (w_pop >= r_free) ? '0 : (r_free - w_pop);

    // word addresses of the mark pointer and the scan cursor
    assign w_mword32   = {15'd0, r_mblk[16:6]};
    assign w_sword32   = {15'd0, r_cur[16:6]};
    assign w_maddr     = w_mword32[AW-1:0];
    assign w_saddr     = w_sword32[AW-1:0];
    assign w_sin_range = (w_sword32 < 32'(MAP_WORDS));

    // byte-lane scan step
    assign w_bits     = r_rdata[{r_cur[5:3], 3'b000} +: 8];
    assign w_vend     = (r_lim[16:3] == r_cur[16:3]) ? {1'b0, r_lim[2:0]} : 4'd8;
    assign w_need_cap = (r_need > bnfra_pkg::t_cnt'(8)) ? 4'd9 : r_need[3:0];

    bnfra_scan u_scan (
        .i_bits     (w_bits),
        .i_off      (r_cur[2:0]),
        .i_vend     (w_vend),
        .i_run_zero (r_run == '0),
        .i_need_cap (w_need_cap),
        .o_res      (w_scan)
    );

    assign w_new_cur   = {r_cur[16:3], 3'b000} + bnfra_pkg::t_cnt'(w_scan.end_pos);
    assign w_word_next = !w_scan.done && (w_scan.end_pos == 4'd8) && (r_cur[5:3] == 3'b111);
    assign w_wrap_lim  = (r_saved < r_total) ? r_saved : r_total;

    // memory port selection
    assign w_we    = i_cmd.sweep_step || i_cmd.mark_wr;
    assign w_waddr = i_cmd.sweep_step ? r_sweep : w_maddr;
    assign w_wdata = i_cmd.sweep_step ? '0 : (r_rdata | w_mask);
    assign w_re    = i_cmd.mark_rd || (i_cmd.scan_rd && w_sin_range);
    assign w_raddr = i_cmd.mark_rd ? w_maddr : w_saddr;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_map[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_map[w_raddr];
        end
    end

    // status to the controller
    always_comb begin
        o_status            = '0;
        o_status.func       = r_func;
        o_status.mark_empty = w_mark_empty;
        o_status.no_space   = (r_free == '0) || (r_total == '0);
        o_status.sweep_last = (r_sweep == AW'(MAP_WORDS - 1));
        o_status.mark_last  = w_last;
        o_status.at_lim     = (r_cur == r_lim);
        o_status.run_zero   = (r_run == '0);
        o_status.wrapped    = r_wrapped;
        o_status.scan_done  = w_scan.done;
        o_status.word_next  = w_word_next;
        o_status.out_free   = !r_out_valid || i_rsp_ready;
    end

    // total, cursor, free count, sweep pointer, response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= bnfra_pkg::t_cnt'(RESET_TOTAL);
            r_cursor    <= '0;
            r_free      <= bnfra_pkg::t_cnt'(RESET_TOTAL);
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_total <= (32'(i_cfg_data) > 32'(MAX_BLOCKS)) ?
                           bnfra_pkg::t_cnt'(MAX_BLOCKS) : i_cfg_data;
            end
            if (i_cmd.clear_init) begin
                r_cursor <= '0;
            end else if (i_cmd.scan_stop) begin
                r_cursor <= r_cur;
            end else if (i_cmd.scan_chunk && w_scan.done) begin
                r_cursor <= w_new_cur;
            end
            if (i_cmd.clear_init) begin
                r_free <= r_total;
            end else if (i_cmd.mark_wr) begin
                r_free <= w_free_dec;
            end
            if (i_cmd.clear_init) begin
                r_sweep <= '0;
            end else if (i_cmd.sweep_step) begin
                r_sweep <= r_sweep + AW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request, mark range and scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_func  <= bnfra_pkg::t_func'(i_req_func);
            r_first <= i_req_first;
            r_len   <= i_req_len;
        end
        if (i_cmd.mark_init) begin
            r_mblk <= {1'b0, r_first};
            r_hi   <= w_mark_hi;
        end else if (i_cmd.alloc_mark_init) begin
            r_mblk <= r_start;
            r_hi   <= r_start + r_run;
        end else if (i_cmd.mark_wr) begin
            r_mblk <= {r_mblk[16:6] + 11'd1, 6'd0};
        end
        if (i_cmd.scan_init) begin
            r_saved <= r_cursor;
            r_run   <= '0;
            r_need  <= w_want;
            r_start <= '0;
            r_lim   <= r_total;
            if (r_cursor >= r_total) begin
                r_cur     <= '0;
                r_wrapped <= 1'b1;
            end else begin
                r_cur     <= r_cursor;
                r_wrapped <= 1'b0;
            end
        end else if (i_cmd.scan_wrap) begin
            r_cur     <= '0;
            r_wrapped <= 1'b1;
            r_lim     <= w_wrap_lim;
        end else if (i_cmd.scan_chunk) begin
            r_cur  <= w_new_cur;
            r_run  <= r_run + bnfra_pkg::t_cnt'(w_scan.k);
            r_need <= r_need - bnfra_pkg::t_cnt'(w_scan.k);
            if (w_scan.start_hit) begin
                r_start <= {r_cur[16:3], w_scan.start_off};
            end
        end
    end

    // response word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.res_kind)
                bnfra_pkg::RES_GRANT: begin
                    r_out_start  <= r_start[15:0];
                    r_out_count  <= r_run;
                    r_out_status <= 1'b0;
                end
                bnfra_pkg::RES_NOSPACE: begin
                    r_out_start  <= '0;
                    r_out_count  <= '0;
                    r_out_status <= 1'b1;
                end
                default: begin
                    r_out_start  <= '0;
                    r_out_count  <= '0;
                    r_out_status <= 1'b0;
                end
            endcase
        end
    end

    assign o_rsp_valid  = r_out_valid;
    assign o_rsp_start  = r_out_start;
    assign o_rsp_count  = r_out_count;
    assign o_rsp_status = r_out_status;

    // scan cursor stays below its limit while lanes are examined
    a_scan_below_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_chunk |-> (r_cur < r_lim))
        else $error("scan cursor at or past its limit");

    // a scan step always has blocks left to find
    a_scan_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_chunk |-> (r_need != '0))
        else $error("scan step with nothing left to find");

    // every marked word lies inside the range
    a_mark_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mark_wr |-> (r_mblk < r_hi))
        else $error("mark pointer beyond the range end");

    // a grant never carries an empty run
    a_grant_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && (i_cmd.res_kind == bnfra_pkg::RES_GRANT)) |-> (r_run != '0))
        else $error("grant with zero blocks");

    // a response word is never loaded over one still waiting
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_rsp_ready))
        else $error("response overwritten while stalled");

endmodule

>>> design/bitmap_next_fit_run_allocator.sv
// Bitmap next-fit run allocator, top level.
// Request channel i_req carries func (clear, mark range, allocate run), first_block and
// run_length; one response word per request leaves on o_rsp with granted_start,
// granted_count and status (1 = no free space). Channel i_cfg writes blocks_in_use,
// which is to be written only while the block is idle; the block itself does not
// enforce this. It is always ready. One request is worked at a time. Steps per request:
//   clear: a sweep writes one map word per cycle,
//   mark: a read, then a write, on one word port per map word the range touches,
//   allocate: map words are read and scanned byte lane by byte lane; the scan wraps or
//     stops each time it meets its limit, then the map words the granted run touches are
//     marked as for mark; no space up front skips the scan.
// Reset zeroes the cursor and the response valid, loads the free count with the total,
// then sweeps all MAP_WORDS map words (1024 at the default size) to zero with
// i_req.ready low.
// The response sits in an output register; the next request is accepted while it waits,
// and a finished result waits in its final state until the register frees.
// depends on bnfra_pkg, bnfra_if, bnfra_ctrl and bnfra_dp

module bitmap_next_fit_run_allocator #(
    parameter int MAX_BLOCKS = bnfra_pkg::MAX_BLOCKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bnfra_req_if.sink   i_req,
    bnfra_rsp_if.source o_rsp,
    bnfra_cfg_if.sink   i_cfg
);

    bnfra_pkg::t_dp_cmd    w_cmd;
    bnfra_pkg::t_dp_status w_status;

    // register port takes every word
    assign i_cfg.ready = 1'b1;

    bnfra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    bnfra_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_req_func   (i_req.func),
        .i_req_first  (i_req.first_block),
        .i_req_len    (i_req.run_length),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_data   (i_cfg.blocks_in_use),
        .i_rsp_ready  (o_rsp.ready),
        .o_rsp_valid  (o_rsp.valid),
        .o_rsp_start  (o_rsp.granted_start),
        .o_rsp_count  (o_rsp.granted_count),
        .o_rsp_status (o_rsp.status)
    );

endmodule
